// ===== hdl/sepl_pkg.sv =====
package sepl_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_APPEND = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;

	localparam logic [CFG_AW-1:0] CFG_ENABLE       = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_LOOP_ENABLE  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_DELAY        = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_GRID         = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_END_PATTERN  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_START_OFFSET = 3'd5;

	typedef struct packed {
		op_t         op;
		logic [31:0] event_time;
		logic [15:0] neuron;
	} in_item_t;

	typedef struct packed {
		logic        spike_valid;
		logic [15:0] spike_neuron;
		logic        last;
		status_t     status;
	} out_item_t;

	typedef struct packed {
		logic [31:0] etime;
		logic [15:0] neuron;
	} event_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_CHECK,
		S_END,
		S_DIV,
		S_FIX,
		S_CLOSE
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic rd_first;
		logic emit;
		logic rd_next;
		logic zero_reset_at;
		logic div_start;
		logic fix;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic play_go;
		logic can_read;
		logic hit;
		logic next_ok;
		logic need_loop;
		logic end_reached;
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/sepl_rem_div.sv =====
module sepl_rem_div import sepl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] rem
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// Restoring division, one quotient bit a cycle; only the remainder is kept.
	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff[31:0];
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/sepl_datapath.sv =====
module sepl_datapath import sepl_pkg::*; #(
	parameter int unsigned TABLE_DEPTH         = 1024,
	parameter int unsigned MAX_SPIKES_PER_TICK = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  in_item_t          in_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned NW = $clog2(MAX_SPIKES_PER_TICK + 1);

	// Configuration registers.
	logic        enable_q;
	logic        loop_en_q;
	logic [31:0] delay_q;
	logic [31:0] grid_q;
	logic [31:0] end_q;

	// Playback state.
	logic [31:0]   clock_q;
	logic [31:0]   offset_q;
	logic [31:0]   reset_at_q;
	logic [CW-1:0] pp_q;
	logic [CW-1:0] count_q;
	logic [31:0]   last_time_q;
	logic [NW-1:0] spk_cnt_q;

	// Item and working registers.
	in_item_t    item_q;
	status_t     status_q;
	logic [31:0] rel_q;
	logic [31:0] t_q;
	logic [31:0] g_q;
	event_t      rd_q;
	logic        out_valid_q;
	out_item_t   out_q;

	event_t mem [TABLE_DEPTH];

	logic          is_tick;
	logic          is_append;
	logic          is_clear;
	logic          full;
	logic          order_bad;
	logic          rewind;
	logic [CW-1:0] pp_inc;
	logic [NW:0]   spk_inc;
	logic [CW-1:0] rd_addr;
	logic [31:0]   loop_t;
	logic [31:0]   grid_eff;
	logic [31:0]   adj;
	logic          div_busy;
	logic [31:0]   div_rem;

	assign is_tick   = (item_q.op == OP_TICK);
	assign is_append = (item_q.op == OP_APPEND);
	assign is_clear  = (item_q.op == OP_CLEAR);
	assign full      = (count_q >= CW'(TABLE_DEPTH));
	assign order_bad = (count_q != '0) && (item_q.event_time < last_time_q);
	assign rewind    = stat.play_go && (clock_q == reset_at_q);
	assign pp_inc    = pp_q + CW'(1);
	assign spk_inc   = {1'b0, spk_cnt_q} + (NW+1)'(1);
	assign rd_addr   = cmd.rd_first ? pp_q : pp_inc;
	assign loop_t    = clock_q + delay_q;
	assign grid_eff  = (grid_q == '0) ? 32'd1 : grid_q;
	assign adj       = (div_rem != '0) ? (g_q - div_rem) : 32'd0;

	sepl_rem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (loop_t),
		.divisor  (grid_eff),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_comb begin
		stat.is_tick     = is_tick;
		stat.play_go     = enable_q && (count_q != '0);
		stat.can_read    = (spk_cnt_q < NW'(MAX_SPIKES_PER_TICK)) && (pp_q < count_q);
		stat.hit         = (rd_q.etime <= rel_q);
		stat.next_ok     = (spk_inc < (NW+1)'(MAX_SPIKES_PER_TICK)) && (pp_inc < count_q);
		stat.need_loop   = (pp_q >= count_q) && (reset_at_q < clock_q) && loop_en_q;
		stat.end_reached = (end_q != '0) && (clock_q >= end_q);
		stat.div_busy    = div_busy;
		stat.out_free    = !out_valid_q || out_ready;
	end

	// Configuration and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			loop_en_q   <= 1'b0;
			delay_q     <= '0;
			grid_q      <= 32'd1;
			end_q       <= '0;
			clock_q     <= '0;
			offset_q    <= '0;
			reset_at_q  <= '0;
			pp_q        <= '0;
			count_q     <= '0;
			spk_cnt_q   <= '0;
			item_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_ENABLE:       enable_q <= cfg_wdata[0];
					CFG_LOOP_ENABLE:  loop_en_q <= cfg_wdata[0];
					CFG_DELAY:        delay_q <= cfg_wdata;
					CFG_GRID:         grid_q <= cfg_wdata;
					CFG_END_PATTERN:  end_q <= cfg_wdata;
					CFG_START_OFFSET: reset_at_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (cmd.accept) begin
				item_q <= in_data;
			end

			if (cmd.exec) begin
				if (is_append && !full && !order_bad) begin
					count_q <= count_q + CW'(1);
				end
				if (is_clear) begin
					count_q <= '0;
					pp_q    <= '0;
				end
				if (is_tick) begin
					spk_cnt_q <= '0;
					if (rewind) begin
						pp_q     <= '0;
						offset_q <= clock_q;
					end
				end
			end

			if (cmd.emit) begin
				pp_q      <= pp_inc;
				spk_cnt_q <= spk_inc[NW-1:0];
			end

			if (cmd.zero_reset_at) begin
				reset_at_q <= '0;
			end
			if (cmd.fix) begin
				reset_at_q <= t_q + adj - 32'd1;
			end

			if (cmd.close && is_tick) begin
				clock_q <= clock_q + 32'd1;
			end

			if (cmd.emit || cmd.close) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_append && full) begin
				status_q <= ST_FULL;
			end else if (is_append && order_bad) begin
				status_q <= ST_ORDER;
			end else begin
				status_q <= ST_OK;
			end
			if (is_append && !full && !order_bad) begin
				last_time_q <= item_q.event_time;
			end
			// After a rewind the offset equals the clock, so the relative time is zero.
			rel_q <= rewind ? 32'd0 : (clock_q - offset_q);
		end
		if (cmd.div_start) begin
			t_q <= loop_t;
			g_q <= grid_eff;
		end
		if (cmd.emit) begin
			out_q.spike_valid  <= 1'b1;
			out_q.spike_neuron <= rd_q.neuron;
			out_q.last         <= 1'b0;
			out_q.status       <= ST_OK;
		end else if (cmd.close) begin
			out_q.spike_valid  <= 1'b0;
			out_q.spike_neuron <= '0;
			out_q.last         <= 1'b1;
			out_q.status       <= status_q;
		end
	end

	// Event store: one write port for appends, one registered read port for playback.
	always_ff @(posedge clk) begin
		if (cmd.exec && is_append && !full && !order_bad) begin
			mem[count_q[AW-1:0]] <= '{etime: item_q.event_time, neuron: item_q.neuron};
		end
		if (cmd.rd_first || cmd.rd_next) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/sepl_ctrl.sv =====
module sepl_ctrl import sepl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = (stat.is_tick && stat.play_go) ? S_READ : S_CLOSE;
			end
			S_READ: begin
				state_d = stat.can_read ? S_CHECK : S_END;
			end
			S_CHECK: begin
				if (!stat.hit) begin
					state_d = S_END;
				end else if (stat.out_free && !stat.next_ok) begin
					state_d = S_END;
				end
			end
			S_END: begin
				if (stat.need_loop && !stat.end_reached) begin
					state_d = S_DIV;
				end else begin
					state_d = S_CLOSE;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				state_d = S_CLOSE;
			end
			S_CLOSE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_READ: begin
				cmd.rd_first = stat.can_read;
			end
			S_CHECK: begin
				// Emit the fetched event and fetch the following one in the same cycle.
				if (stat.hit && stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.rd_next = stat.next_ok;
				end
			end
			S_END: begin
				if (stat.need_loop) begin
					cmd.zero_reset_at = stat.end_reached;
					cmd.div_start     = !stat.end_reached;
				end
			end
			S_DIV: ;
			S_FIX: begin
				cmd.fix = 1'b1;
			end
			S_CLOSE: begin
				cmd.close = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/spike_event_playback_looper.sv =====
// Spike event playback looper. Events (time relative to loop start, neuron id) are appended
// in time order into an on-chip table; out-of-order appends and appends to a full table are
// refused with a status. Each tick item rewinds playback at the scheduled reset tick, emits
// one spike item per due event (at most MAX_SPIKES_PER_TICK per tick, the rest wait for later
// ticks) and closes with an item marked last; append, clear and other ops give one closing
// item with their status. Items are handled one at a time. An append, a clear, another op or
// a tick with playback off or an empty table goes straight from execution to its closing
// item; a playing tick first reads and emits the due events, and when the next loop start
// is computed the grid alignment waits on a 32-step serial remainder unit. A full output
// register stalls the work until the item is taken.
module spike_event_playback_looper import sepl_pkg::*; #(
	parameter int unsigned TABLE_DEPTH         = 1024,
	parameter int unsigned MAX_SPIKES_PER_TICK = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	sepl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sepl_datapath #(
		.TABLE_DEPTH         (TABLE_DEPTH),
		.MAX_SPIKES_PER_TICK (MAX_SPIKES_PER_TICK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/sepl_checker.sv =====
module sepl_checker import sepl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// Items are worked one at a time, so input is refused right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// A spike item is never the closing item and always carries status ok.
	a_spike_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.spike_valid |-> !out_data.last && out_data.status == ST_OK)
		else $error("spike item with last or status set");

	// Every item that is not a spike closes its input with neuron zero.
	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.spike_valid |-> out_data.last && out_data.spike_neuron == '0)
		else $error("malformed closing item");

endmodule

bind spike_event_playback_looper sepl_checker u_sepl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/tb_spike_event_playback_looper.sv =====
module tb_spike_event_playback_looper;
	import sepl_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned SPIKE_CAP = 63;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_BUDGET = 25;
	localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		in_item_t item;
		bit       hold_for_drain;
	} pend_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	pend_t     pending_ops[$];
	out_item_t spike_q[$];

	// Register copies and playback state of the looper as the testbench tracks it.
	logic        r_enable;
	logic        r_loop;
	logic [31:0] r_delay;
	logic [31:0] r_grid;
	logic [31:0] r_end_pattern;
	logic [31:0] tick_clock;
	logic [31:0] loop_base;
	logic [31:0] rewind_tick;
	int unsigned play_idx;
	int unsigned n_events;
	logic [31:0] ev_time [TABLE_DEPTH];
	logic [15:0] ev_neuron [TABLE_DEPTH];

	int unsigned tx_idle_pct = 33;
	int unsigned rx_idle_pct = 68;
	int unsigned phase_count;
	int unsigned stall_cycles = 0;
	int unsigned n_in = 0;
	int unsigned n_out = 0;
	int unsigned n_ticks = 0;
	int unsigned n_spikes = 0;
	int unsigned n_rewinds = 0;
	int unsigned n_rejects = 0;
	int unsigned n_mismatch = 0;

	spike_event_playback_looper #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_SPIKES_PER_TICK(SPIKE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic advance_playback(input in_item_t it);
		logic [31:0] rel;
		logic [31:0] grid;
		logic [31:0] start;
		int unsigned burst;
		out_item_t closing;
		out_item_t spike;
		burst = 0;
		closing = '{1'b0, 16'd0, 1'b1, ST_OK};
		case (it.op)
			OP_APPEND: begin
				if (n_events >= TABLE_DEPTH)
					closing.status = ST_FULL;
				else if (n_events > 0 && it.event_time < ev_time[n_events - 1])
					closing.status = ST_ORDER;
				else begin
					ev_time[n_events] = it.event_time;
					ev_neuron[n_events] = it.neuron;
					n_events++;
				end
				if (closing.status != ST_OK)
					n_rejects++;
			end
			OP_CLEAR: begin
				n_events = 0;
				play_idx = 0;
			end
			OP_TICK: begin
				if (r_enable && n_events > 0) begin
					if (tick_clock == rewind_tick) begin
						play_idx = 0;
						loop_base = tick_clock;
						n_rewinds++;
					end
					rel = tick_clock - loop_base;
					while (burst < SPIKE_CAP && play_idx < n_events &&
							ev_time[play_idx] <= rel) begin
						spike = '{1'b1, ev_neuron[play_idx], 1'b0, ST_OK};
						spike_q.insert(spike_q.size(), spike);
						burst++;
						play_idx++;
					end
					if (play_idx >= n_events && rewind_tick < tick_clock && r_loop) begin
						if (r_end_pattern != 32'd0 && tick_clock >= r_end_pattern) begin
							rewind_tick = 32'd0;
						end else begin
							// Round clock plus delay up to the grid, then step back one tick.
							grid = (r_grid == 32'd0) ? 32'd1 : r_grid;
							start = tick_clock + r_delay;
							if (start % grid != 32'd0)
								start = (start / grid + 32'd1) * grid;
							rewind_tick = start - 32'd1;
						end
					end
				end
				tick_clock++;
				n_ticks++;
				n_spikes += burst;
			end
			OP_NONE: ;
			default: ;
		endcase
		spike_q.insert(spike_q.size(), closing);
	endtask

	function automatic void queue_op(op_t op, logic [31:0] t, logic [15:0] nid, bit hold);
		pend_t p;
		p.item = '{op, t, nid};
		p.hold_for_drain = hold;
		pending_ops.insert(pending_ops.size(), p);
		if (op != OP_NONE)
			phase_count++;
	endfunction

	function automatic void note_mismatch(string why, out_item_t want, out_item_t got);
		n_mismatch++;
		if (n_mismatch <= 10) begin
			$display("%s: expected valid=%0b neuron=%h last=%0b status=%0d",
				why, want.spike_valid, want.spike_neuron, want.last, want.status);
			$display("    got valid=%0b neuron=%h last=%0b status=%0d",
				got.spike_valid, got.spike_neuron, got.last, got.status);
		end
	endfunction

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ENABLE: r_enable = val[0];
			CFG_LOOP_ENABLE: r_loop = val[0];
			CFG_DELAY: r_delay = val;
			CFG_GRID: r_grid = val;
			CFG_END_PATTERN: r_end_pattern = val;
			CFG_START_OFFSET: rewind_tick = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || spike_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: keeps an item on the bus until it is taken, then maybe idles.
	always @(posedge clk or negedge arst_n) begin
		bit send;
		pend_t head;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_playback(in_data);
				n_in++;
			end
			if (!in_valid || in_ready) begin
				send = pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct;
				if (send && pending_ops[0].hold_for_drain)
					send = !in_valid && spike_q.size() == 0;
				in_valid <= send;
				if (send) begin
					head = pending_ops.pop_front();
					in_data <= head.item;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_out++;
				if (spike_q.size() == 0) begin
					note_mismatch("unexpected result", '0, out_data);
				end else begin
					want = spike_q.pop_front();
					if (out_data.spike_valid !== want.spike_valid ||
							out_data.spike_neuron !== want.spike_neuron ||
							out_data.last !== want.last || out_data.status !== want.status)
						note_mismatch("result mismatch", want, out_data);
				end
			end
			out_ready <= $urandom_range(99) >= rx_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", stall_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned k;
		int unsigned m;
		logic [31:0] t;
		logic [31:0] en;
		logic [31:0] lp;
		logic [31:0] dl;
		logic [31:0] gr;
		logic [31:0] ep;
		logic [31:0] so;
		r_enable = 1'b1;
		r_loop = 1'b0;
		r_delay = 32'd0;
		r_grid = 32'd1;
		r_end_pattern = 32'd0;
		tick_clock = 32'd0;
		loop_base = 32'd0;
		rewind_tick = 32'd0;
		play_idx = 0;
		n_events = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items on the reset register values.
		queue_op(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_op(OP_TICK, 32'd0, 16'd0, 1'b0);
		queue_op(OP_APPEND, 32'd0, 16'd0, 1'b0);
		queue_op(OP_APPEND, 32'd5, 16'hFFFF, 1'b0);
		queue_op(OP_APPEND, 32'd3, 16'h1234, 1'b0);
		queue_op(OP_APPEND, 32'd5, 16'hA5A5, 1'b0);
		queue_op(OP_APPEND, 32'hFFFF_FFFF, 16'h8000, 1'b0);
		queue_op(OP_APPEND, 32'd0, 16'h0001, 1'b0);
		queue_op(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		repeat (5) queue_op(OP_TICK, $urandom(), 16'($urandom()), 1'b0);
		queue_op(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_op(OP_TICK, 32'd0, 16'd0, 1'b0);
		// Everything before this append has to come back first.
		queue_op(OP_APPEND, 32'd0, 16'h5A5A, 1'b1);
		queue_op(OP_TICK, 32'd0, 16'd0, 1'b0);
		queue_op(OP_CLEAR, 32'd0, 16'd0, 1'b0);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				tx_idle_pct = 68;
				rx_idle_pct = 33;
			end else if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// Upper bits of the one-bit registers are set to check that they are dropped.
			case (p)
				0: begin
					en = 32'd1; lp = 32'd1; dl = 32'd3; gr = 32'd4; ep = 32'd0;
					so = tick_clock + 32'd2;
				end
				1: begin
					en = 32'd1; lp = 32'd1; dl = 32'hFFFF_FFFF; gr = 32'd0; ep = 32'd0;
					so = tick_clock + 32'd1;
				end
				2: begin
					en = 32'hFFFF_FFFE; lp = 32'd1; dl = $urandom_range(20);
					gr = $urandom_range(6, 1); ep = 32'd0; so = tick_clock;
				end
				3: begin
					en = 32'd1; lp = 32'hFFFF_FFFF; dl = 32'd0; gr = 32'hFFFF_FFFF;
					ep = tick_clock + 32'd25; so = tick_clock;
				end
				4: begin
					en = 32'd1; lp = 32'd2; dl = $urandom(); gr = $urandom();
					ep = 32'hFFFF_FFFF; so = 32'hFFFF_FFFF;
				end
				default: begin
					en = 32'd1; lp = 32'd1; dl = $urandom_range(10); gr = $urandom_range(8, 1);
					ep = tick_clock + $urandom_range(90, 40);
					so = tick_clock + $urandom_range(5);
				end
			endcase
			write_reg(CFG_ENABLE, en);
			write_reg(CFG_LOOP_ENABLE, lp);
			write_reg(CFG_DELAY, dl);
			write_reg(CFG_GRID, gr);
			write_reg(CFG_END_PATTERN, ep);
			write_reg(CFG_START_OFFSET, so);
			if (p == 0) begin
				write_reg(CFG_SPARE_LO, $urandom());
				write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
			end
			@(posedge clk);
			cfg_we <= 1'b0;
			repeat (2) @(posedge clk);

			if (p == 4) begin
				// A longer table whose first events share a time so ticks hit the cap.
				queue_op(OP_CLEAR, $urandom(), 16'($urandom()), 1'b0);
				for (int i = 0; i < 100; i++)
					queue_op(OP_APPEND, (i < 70) ? 32'd0 : 32'(i / 16),
						16'($urandom()), 1'b0);
				queue_op(OP_APPEND, 32'hFFFF_FFFF, 16'($urandom()), 1'b0);
				queue_op(OP_APPEND, 32'd0, 16'($urandom()), 1'b0);
				repeat (18) queue_op(OP_TICK, $urandom(), 16'($urandom()), 1'b0);
				queue_op(OP_CLEAR, $urandom(), 16'($urandom()), 1'b0);
			end

			phase_count = 0;
			while (phase_count < PHASE_BUDGET) begin
				if ($urandom_range(99) < 80) begin
					// A fresh table of ordered events, now and then with an out-of-order append, then a run of ticks.
					queue_op(OP_CLEAR, $urandom(), 16'($urandom()), $urandom_range(14) == 0);
					k = ($urandom_range(5) == 0) ? $urandom_range(80, 64) : $urandom_range(12, 1);
					t = $urandom_range(3);
					for (int i = 0; i < k; i++) begin
						if (i > 0 && t > 32'd0 && $urandom_range(7) == 0)
							queue_op(OP_APPEND, t - 32'd1, 16'($urandom()), 1'b0);
						if (k <= 12)
							t += $urandom_range(3);
						queue_op(OP_APPEND, t, 16'($urandom()), 1'b0);
					end
					m = $urandom_range(30, 8);
					repeat (m) queue_op(OP_TICK, $urandom(), 16'($urandom()), 1'b0);
				end else begin
					repeat ($urandom_range(6, 2))
						queue_op(op_t'(2'($urandom_range(3))), $urandom(), 16'($urandom()),
							1'b0);
				end
			end
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (spike_q.size() != 0) begin
			$display("%0d expected results never arrived", spike_q.size());
			n_mismatch += spike_q.size();
		end
		$display("Covered %0d items (%0d ticks) and %0d results carrying %0d spikes,",
			n_in, n_ticks, n_out, n_spikes);
		$display("with %0d rewinds and %0d refused appends over six register sets.",
			n_rewinds, n_rejects);
		if (n_mismatch == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", n_mismatch);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sepl_pkg.sv
hdl/sepl_rem_div.sv
hdl/sepl_datapath.sv
hdl/sepl_ctrl.sv
hdl/spike_event_playback_looper.sv
hdl/sepl_checker.sv
test/tb_spike_event_playback_looper.sv
